### rtl/weighted_table_sampler_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef WEIGHTED_TABLE_SAMPLER_UNIT_DEFINES_SVH
`define WEIGHTED_TABLE_SAMPLER_UNIT_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define WTS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define WTS_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### rtl/wts_pkg.sv
`timescale 1ns / 1ps

package wts_pkg;

	localparam int BINS      = 256;
	localparam int ROWS      = 4;
	localparam int MEM_DEPTH = ROWS * BINS;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int CNT_W     = $clog2(BINS + 1);
	localparam int WEIGHT_W  = 16;
	localparam int VALUE_W   = 16;
	localparam int FRAC_W    = 16;
	localparam int TOTAL_W   = 24;
	localparam int CUM_W     = $clog2(BINS) + WEIGHT_W + 1;
	localparam int BIU_W     = 9;
	localparam int PADDR_W   = 3;

	localparam logic [BIU_W-1:0]   BIU_RESET  = 9'd180;
	localparam logic [VALUE_W-1:0] NONE_VALUE = 16'hFF00;

	typedef enum logic [1:0] {
		OP_WR_WEIGHT = 2'd0,
		OP_WR_VALUE  = 2'd1,
		OP_SAMPLE    = 2'd2,
		OP_NOP       = 2'd3
	} op_t;

	typedef enum logic {
		REG_BINS_IN_USE = 1'b0,
		REG_NONE        = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_RD,
		ST_WR_UPD,
		ST_VAL_WR,
		ST_SMP_SETUP,
		ST_WALK
	} state_t;

endpackage

### rtl/weighted_table_sampler_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake                          Payload
// command   start, accepted when busy is low   opcode, row, bin, weight, bin_value,
//                                              random_fraction
// result    done, one-cycle strobe             sample_value, sample_bin, found
// config    APB write, pready always high      pwdata (bins_in_use at 0x0)
//
// Weight write reads the old weight, then writes the new weight and updates the row total; value write is one step.
// A sample reads at most n bins, n the clamped bins_in_use: one weight/value memory
// read per bin, after a setup step for the total scaling multiply, then the result.
// After reset a clearing pass sweeps both 1024-entry memories with busy high.
// The result side has no backpressure; a result is never held.

module weighted_table_sampler_unit import wts_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [PADDR_W-1:0]         paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 opcode,
	input  logic [1:0]                 row,
	input  logic [7:0]                 bin,
	input  logic [WEIGHT_W-1:0]        weight,
	input  logic signed [VALUE_W-1:0]  bin_value,
	input  logic [FRAC_W-1:0]          random_fraction,
	output logic                       done,
	output logic signed [VALUE_W-1:0]  sample_value,
	output logic [7:0]                 sample_bin,
	output logic                       found
);

	state_t state_q, state_d;

	logic [BIU_W-1:0]    bins_in_use_q;
	logic [TOTAL_W-1:0]  row_totals_q [ROWS];

	logic [1:0]          row_q;
	logic [7:0]          bin_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [VALUE_W-1:0]  value_q;
	logic [FRAC_W-1:0]   frac_q;

	logic [ADDR_W-1:0]   clr_q;
	logic [CNT_W-1:0]    k_q;
	logic [CNT_W-1:0]    n_q;
	logic [CUM_W-1:0]    cum_q;
	logic [TOTAL_W-1:0]  scaled_q;
	logic                rd_vld_s1;
	logic [CNT_W-1:0]    rd_k_s1;

	logic [WEIGHT_W-1:0] weight_mem [MEM_DEPTH];
	logic [VALUE_W-1:0]  value_mem  [MEM_DEPTH];
	logic [WEIGHT_W-1:0] w_rdata;
	logic [VALUE_W-1:0]  v_rdata;

	logic                accept;
	logic                cfg_wr;
	logic                row_ok;
	logic                write_ok;
	logic [ADDR_W-1:0]   row_base;
	logic [ADDR_W-1:0]   wr_addr;
	logic [ADDR_W-1:0]   walk_addr;
	logic [TOTAL_W-1:0]  cur_total;
	logic [TOTAL_W-1:0]  new_total;
	logic [TOTAL_W+FRAC_W-1:0] prod;
	logic [CNT_W-1:0]    n_clamp;
	logic [CUM_W-1:0]    sum;
	logic                hit;
	logic                last;

	logic                w_we, v_we, rd_en, tot_we, walk_start, walk_issue;
	logic [ADDR_W-1:0]   waddr, rd_addr;
	logic [WEIGHT_W-1:0] w_wdata;
	logic [VALUE_W-1:0]  v_wdata;
	logic                res_set, res_found;
	logic [VALUE_W-1:0]  res_value;
	logic [7:0]          res_bin;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (reg_idx_t'(paddr[2]) == REG_BINS_IN_USE) ?
		{{(32 - BIU_W){1'b0}}, bins_in_use_q} : 32'd0;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign row_ok    = (int'(row_q) < ROWS);
	assign write_ok  = row_ok && (int'(bin_q) < BINS);
	assign row_base  = ADDR_W'(row_q) * ADDR_W'(BINS);
	assign wr_addr   = row_base + ADDR_W'(bin_q);
	assign walk_addr = row_base + ADDR_W'(k_q);
	assign cur_total = row_ok ? row_totals_q[row_q] : '0;
	assign new_total = cur_total - TOTAL_W'(w_rdata) + TOTAL_W'(weight_q);
	assign prod      = (TOTAL_W+FRAC_W)'(cur_total) * (TOTAL_W+FRAC_W)'(frac_q);
	assign n_clamp   = (bins_in_use_q == '0) ? CNT_W'(1) :
		((int'(bins_in_use_q) > BINS) ? CNT_W'(BINS) : CNT_W'(bins_in_use_q));
	assign sum       = cum_q + CUM_W'(w_rdata);
	assign hit       = (sum > CUM_W'(scaled_q));
	assign last      = (rd_k_s1 == n_q - CNT_W'(1));

	always_comb begin
		state_d    = state_q;
		w_we       = 1'b0;
		v_we       = 1'b0;
		waddr      = wr_addr;
		w_wdata    = weight_q;
		v_wdata    = value_q;
		rd_en      = 1'b0;
		rd_addr    = walk_addr;
		tot_we     = 1'b0;
		walk_start = 1'b0;
		walk_issue = 1'b0;
		res_set    = 1'b0;
		res_found  = 1'b0;
		res_value  = NONE_VALUE;
		res_bin    = '0;
		unique case (state_q)
			ST_CLEAR: begin
				w_we    = 1'b1;
				v_we    = 1'b1;
				waddr   = clr_q;
				w_wdata = '0;
				v_wdata = '0;
				if (clr_q == ADDR_W'(MEM_DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					unique case (op_t'(opcode))
						OP_WR_WEIGHT: state_d = ST_WR_RD;
						OP_WR_VALUE:  state_d = ST_VAL_WR;
						OP_SAMPLE:    state_d = ST_SMP_SETUP;
						OP_NOP:       state_d = ST_IDLE;
						default:      state_d = ST_IDLE;
					endcase
				end
			end
			ST_WR_RD: begin
				if (write_ok) begin
					rd_en   = 1'b1;
					rd_addr = wr_addr;
					state_d = ST_WR_UPD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_WR_UPD: begin
				w_we    = 1'b1;
				tot_we  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_VAL_WR: begin
				v_we    = write_ok;
				state_d = ST_IDLE;
			end
			ST_SMP_SETUP: begin
				if (!row_ok || cur_total == '0) begin
					res_set = 1'b1;
					state_d = ST_IDLE;
				end else begin
					walk_start = 1'b1;
					state_d    = ST_WALK;
				end
			end
			ST_WALK: begin
				if (k_q < n_q) begin
					rd_en      = 1'b1;
					walk_issue = 1'b1;
				end
				if (rd_vld_s1) begin
					if (hit) begin
						res_set   = 1'b1;
						res_found = 1'b1;
						res_value = v_rdata;
						res_bin   = rd_k_s1[7:0];
						state_d   = ST_IDLE;
					end else if (last) begin
						res_set = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			k_q       <= '0;
			rd_vld_s1 <= 1'b0;
			done      <= 1'b0;
		end else begin
			state_q   <= state_d;
			done      <= res_set;
			rd_vld_s1 <= walk_issue && (state_d == ST_WALK);
			if (state_q == ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
			if (walk_start) begin
				k_q <= '0;
			end else if (walk_issue) begin
				k_q <= k_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_in_use_q <= BIU_RESET;
			for (int i = 0; i < ROWS; i++) row_totals_q[i] <= '0;
		end else begin
			if (cfg_wr && reg_idx_t'(paddr[2]) == REG_BINS_IN_USE) begin
				bins_in_use_q <= pwdata[BIU_W-1:0];
			end
			if (tot_we) row_totals_q[row_q] <= new_total;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q    <= row;
			bin_q    <= bin;
			weight_q <= weight;
			value_q  <= bin_value;
			frac_q   <= random_fraction;
		end
		if (walk_start) begin
			scaled_q <= prod[TOTAL_W+FRAC_W-1:FRAC_W];
			n_q      <= n_clamp;
			cum_q    <= '0;
		end else if (rd_vld_s1) begin
			cum_q <= sum;
		end
		rd_k_s1 <= k_q;
		if (res_set) begin
			sample_value <= res_value;
			sample_bin   <= res_bin;
			found        <= res_found;
		end
	end

	always_ff @(posedge clk) begin
		if (w_we) weight_mem[waddr] <= w_wdata;
		if (rd_en) w_rdata <= weight_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (v_we) value_mem[waddr] <= v_wdata;
		if (rd_en) v_rdata <= value_mem[rd_addr];
	end

endmodule

### rtl/wts_checker.sv
`timescale 1ns / 1ps
`include "weighted_table_sampler_unit_defines.svh"

module wts_checker import wts_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic [1:0]                opcode,
	input logic                      done,
	input logic signed [VALUE_W-1:0] sample_value,
	input logic [7:0]                sample_bin,
	input logic                      found
);

	`WTS_ASSERT(a_done_after_busy, done |-> $past(busy), "result without a transaction in flight")

	`WTS_ASSERT(a_done_single, done |=> !done, "result strobe longer than one cycle")

	`WTS_ASSERT(a_accept_busy, (start && !busy && op_t'(opcode) != OP_NOP) |=> busy, "transaction accepted but block not busy")

	`WTS_NEVER(a_none_result, done && !found && (sample_value != NONE_VALUE || sample_bin != 8'd0), "not-found result with wrong payload")

endmodule

bind weighted_table_sampler_unit wts_checker u_wts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.opcode       (opcode),
	.done         (done),
	.sample_value (sample_value),
	.sample_bin   (sample_bin),
	.found        (found)
);

### dv/tb_weighted_table_sampler_unit.sv
`timescale 1ns / 1ps

module tb_weighted_table_sampler_unit;
	import wts_pkg::*;

	typedef struct packed {
		op_t                 op;
		logic [1:0]          row;
		logic [7:0]          bin;
		logic [WEIGHT_W-1:0] weight;
		logic [VALUE_W-1:0]  value;
		logic [FRAC_W-1:0]   frac;
	} command_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [7:0]         bin;
		logic               found;
	} draw_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [PADDR_W-1:0]        paddr = '0;
	logic [31:0]               pwdata = '0;
	logic [31:0]               prdata;
	logic                      pready;
	logic                      start = 1'b0;
	logic                      busy;
	logic [1:0]                opcode = '0;
	logic [1:0]                row = '0;
	logic [7:0]                bin = '0;
	logic [WEIGHT_W-1:0]       weight = '0;
	logic signed [VALUE_W-1:0] bin_value = '0;
	logic [FRAC_W-1:0]         random_fraction = '0;
	logic                      done;
	logic signed [VALUE_W-1:0] sample_value;
	logic [7:0]                sample_bin;
	logic                      found;

	weighted_table_sampler_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.start           (start),
		.busy            (busy),
		.opcode          (opcode),
		.row             (row),
		.bin             (bin),
		.weight          (weight),
		.bin_value       (bin_value),
		.random_fraction (random_fraction),
		.done            (done),
		.sample_value    (sample_value),
		.sample_bin      (sample_bin),
		.found           (found)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow copy of the tables
	logic [WEIGHT_W-1:0] weight_mem [MEM_DEPTH];
	logic [VALUE_W-1:0]  value_mem [MEM_DEPTH];
	logic [TOTAL_W-1:0]  row_sum [ROWS];
	logic [BIU_W-1:0]    bins_used = BIU_RESET;

	command_t pending_cmds [$];
	draw_t    draws_expected [$];
	command_t active_cmd;
	int       idle_pct = 0;
	bit       hold_for_draws = 1'b0;
	int       errors = 0;

	initial begin
		for (int i = 0; i < MEM_DEPTH; i++) begin
			weight_mem[i] = '0;
			value_mem[i] = '0;
		end
		for (int r = 0; r < ROWS; r++)
			row_sum[r] = '0;
	end

	function automatic void apply_command(input command_t c);
		int unsigned        addr;
		int unsigned        n;
		logic [39:0]        scaled;
		logic [31:0]        cum;
		logic [TOTAL_W-1:0] total;
		draw_t              d;
		begin
			addr = int'(c.row) * BINS + int'(c.bin);
			case (c.op)
				OP_WR_WEIGHT: begin
					row_sum[c.row] = row_sum[c.row] - weight_mem[addr] + c.weight;
					weight_mem[addr] = c.weight;
				end
				OP_WR_VALUE: begin
					value_mem[addr] = c.value;
				end
				OP_SAMPLE: begin
					d.value = NONE_VALUE;
					d.bin = '0;
					d.found = 1'b0;
					total = row_sum[c.row];
					if (total != '0) begin
						n = bins_used;
						if (n == 0)
							n = 1;
						if (n > BINS)
							n = BINS;
						scaled = ({16'd0, total} * {24'd0, c.frac}) >> 16;
						cum = '0;
						for (int k = 0; k < n; k++) begin
							if (!d.found) begin
								cum = cum + weight_mem[int'(c.row) * BINS + k];
								if ({8'd0, cum} > scaled) begin
									d.value = value_mem[int'(c.row) * BINS + k];
									d.bin = k[7:0];
									d.found = 1'b1;
								end
							end
						end
					end
					draws_expected.push_back(d);
				end
				default: ;
			endcase
		end
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				apply_command(active_cmd);
			if (!start || !busy) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct
						&& !(hold_for_draws && draws_expected.size() != 0)) begin
					active_cmd = pending_cmds.pop_front();
					opcode <= active_cmd.op;
					row <= active_cmd.row;
					bin <= active_cmd.bin;
					weight <= active_cmd.weight;
					bin_value <= active_cmd.value;
					random_fraction <= active_cmd.frac;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (draws_expected.size() == 0) begin
				$display("%0t: unexpected result value %0d bin %0d found %0b", $time,
					sample_value, sample_bin, found);
				errors++;
			end else begin
				draw_t d;
				d = draws_expected.pop_front();
				if (sample_value !== $signed(d.value)) begin
					$display("%0t: sample_value expected %0d actual %0d", $time,
						$signed(d.value), sample_value);
					errors++;
				end
				if (sample_bin !== d.bin) begin
					$display("%0t: sample_bin expected %0d actual %0d", $time,
						d.bin, sample_bin);
					errors++;
				end
				if (found !== d.found) begin
					$display("%0t: found expected %0b actual %0b", $time, d.found, found);
					errors++;
				end
			end
		end
	end

	task automatic queue_command(input op_t op, input int r, input int b, input int w,
			input int v, input int f);
		command_t c;
		c.op = op;
		c.row = r[1:0];
		c.bin = b[7:0];
		c.weight = w[15:0];
		c.value = v[15:0];
		c.frac = f[15:0];
		pending_cmds.push_back(c);
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_cmds.size() != 0 || start || busy || draws_expected.size() != 0);
		repeat (12) @(negedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(int'(idx) * 4);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_BINS_IN_USE)
			bins_used = data[BIU_W-1:0];
	endtask

	task automatic queue_random(input int count);
		int    span;
		int    pick;
		int    w;
		int    b;
		int    f;
		op_t   op;
		span = (bins_used == 0) ? 1 : ((bins_used > BINS) ? BINS : int'(bins_used));
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 45)
				op = OP_WR_WEIGHT;
			else if (pick < 63)
				op = OP_WR_VALUE;
			else if (pick < 95)
				op = OP_SAMPLE;
			else
				op = OP_NOP;
			pick = $urandom_range(99);
			if (pick < 25)
				w = 0;
			else if (pick < 50)
				w = $urandom_range(15, 1);
			else if (pick < 90)
				w = $urandom_range(16'hFFFF);
			else
				w = 16'hFFFF;
			b = ($urandom_range(99) < 75) ? $urandom_range(span - 1) : $urandom_range(255);
			pick = $urandom_range(99);
			f = (pick < 8) ? 0 : ((pick < 16) ? 16'hFFFF : $urandom_range(16'hFFFF));
			queue_command(op, $urandom_range(ROWS - 1), b, w, $urandom_range(16'hFFFF), f);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty row, extremes, edges, walk past bins in use
		queue_command(OP_SAMPLE, 3, 0, 0, 0, 16'h1234);
		queue_command(OP_WR_WEIGHT, 0, 0, 16'hFFFF, 0, 0);
		queue_command(OP_WR_VALUE, 0, 0, 0, 16'h7FFF, 0);
		queue_command(OP_WR_WEIGHT, 0, 255, 1, 0, 0);
		queue_command(OP_WR_VALUE, 0, 255, 0, 16'h8000, 0);
		queue_command(OP_SAMPLE, 0, 0, 0, 0, 0);
		queue_command(OP_SAMPLE, 0, 0, 0, 0, 16'hFFFF);
		queue_command(OP_WR_WEIGHT, 1, 0, 1, 0, 0);
		queue_command(OP_WR_WEIGHT, 1, 2, 1, 0, 0);
		queue_command(OP_WR_VALUE, 1, 2, 0, 16'h0180, 0);
		queue_command(OP_SAMPLE, 1, 0, 0, 0, 16'h8000);
		queue_command(OP_WR_WEIGHT, 1, 0, 0, 0, 0);
		queue_command(OP_SAMPLE, 1, 0, 0, 0, 0);
		queue_command(OP_NOP, 3, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_command(OP_WR_WEIGHT, 3, 7, 5, 0, 0);
		queue_command(OP_WR_WEIGHT, 3, 7, 0, 0, 0);
		queue_command(OP_SAMPLE, 3, 7, 0, 0, 16'h4000);
		queue_command(OP_WR_WEIGHT, 2, 179, 16'hFFFF, 0, 0);
		queue_command(OP_WR_VALUE, 2, 179, 0, 16'h8000, 0);
		queue_command(OP_SAMPLE, 2, 0, 0, 0, 16'hFFFF);
		queue_command(OP_SAMPLE, 2, 0, 0, 0, 16'h0001);
		wait_idle();

		apb_write(REG_BINS_IN_USE, 32'd256);
		apb_write(REG_NONE, 32'hFFFF_FFFF);
		queue_command(OP_SAMPLE, 0, 0, 0, 0, 16'hFFFF);
		queue_random(270);
		wait_idle();

		apb_write(REG_BINS_IN_USE, 32'd1);
		idle_pct = 78;
		queue_random(270);
		wait_idle();

		apb_write(REG_BINS_IN_USE, 32'd0);
		idle_pct = 0;
		hold_for_draws = 1'b1;
		queue_random(270);
		wait_idle();

		apb_write(REG_BINS_IN_USE, 32'd511);
		hold_for_draws = 1'b0;
		idle_pct = 27;
		queue_random(270);
		wait_idle();

		apb_write(REG_BINS_IN_USE, $urandom_range(255, 2));
		idle_pct = 0;
		queue_random(270);
		wait_idle();

		if (errors == 0 && draws_expected.size() == 0)
			$display("[weighted_table_sampler_unit] OK");
		else
			$display("[weighted_table_sampler_unit] ERROR");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("[weighted_table_sampler_unit] ERROR");
		$finish;
	end

endmodule
